/* design/rks_pkg.sv */
// rks_pkg: shared types and constants for the running k-th smallest block
// used by running_kth_smallest and its port checker; no dependencies
package rks_pkg;

  localparam int MAX_KEEP_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths on the ports
  localparam int SAMPLE_BITS = 32;
  localparam int KEEP_BITS   = 5;
  localparam int COUNT_BITS  = 5;
  localparam int OUT_BITS    = 40;

  localparam logic [KEEP_BITS-1:0] KEEP_RESET = 5'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_REPL,
    ST_SCAN,
    ST_DONE
  } rks_state_t;

endpackage

/* design/running_kth_smallest.sv */
// running_kth_smallest: keeps the k smallest values since the last restart
// and reports the largest of them; depends on rks_pkg
// order: an appended value is written and then the store rescanned (ST_SCAN) for its largest;
//   otherwise ST_FIND scans for the largest, ST_REPL compares, and a replacement rescans;
//   one shared signed comparator scans the value memory one entry per cycle
// flow: one item at a time; in_tready comes back with out_tvalid, and a stalled result
//   holds off the next result
// reset: held count cleared, keep_count back to 1, stored values left as they are
module running_kth_smallest #(
  parameter int MAX_KEEP   = rks_pkg::MAX_KEEP_DEF,
  parameter int VALUE_BITS = rks_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rks_pkg::SAMPLE_BITS-1:0] in_tdata,   // [31:0] sample_value
  input  logic                           in_tuser,   // [0] restart
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] kth_smallest, [36:32] held_count, [37] store_full, [39:38] zero
  output logic [rks_pkg::OUT_BITS-1:0]    out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rks_pkg::KEEP_BITS-1:0]   cfg_data    // [4:0] keep_count
);

  localparam int CNT_W  = $clog2(MAX_KEEP + 1);
  localparam int ADDR_W = $clog2(MAX_KEEP);
  localparam int KW     = (CNT_W > rks_pkg::KEEP_BITS) ? CNT_W : rks_pkg::KEEP_BITS;

  rks_pkg::rks_state_t state_r, state_nxt;

  logic [rks_pkg::KEEP_BITS-1:0] keep_r;
  logic [CNT_W-1:0]      held_r, held_nxt;
  logic [VALUE_BITS-1:0] x_r, x_nxt;
  logic [VALUE_BITS-1:0] best_val_r, best_val_nxt;
  logic [ADDR_W-1:0]     best_idx_r, best_idx_nxt;
  logic [CNT_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                  pend_r, pend_nxt;
  logic                  first_r, first_nxt;
  logic [ADDR_W-1:0]     data_idx_r, data_idx_nxt;
  logic [VALUE_BITS-1:0] rd_data_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_value_r, out_value_nxt;
  logic [rks_pkg::COUNT_BITS-1:0] out_held_r, out_held_nxt;
  logic                  out_full_r, out_full_nxt;

  logic [VALUE_BITS-1:0] mem [MAX_KEEP];
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic [ADDR_W-1:0]     rd_addr;

  logic [KW-1:0]         keep_ext, keep_eff;
  logic [CNT_W-1:0]      held_base;
  logic                  append, full;
  logic                  issue, in_xfer;
  logic [VALUE_BITS-1:0] cmp_a, cmp_b;
  logic                  cmp_lt;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == rks_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_full_r, out_held_r, out_value_r};

  // zero acts as one, large values saturate at the store depth
  assign keep_ext = KW'(keep_r);
  assign keep_eff = (keep_ext == '0) ? KW'(1) :
                    ((keep_ext > KW'(MAX_KEEP)) ? KW'(MAX_KEEP) : keep_ext);
  assign held_base = in_tuser ? '0 : held_r;
  assign append    = KW'(held_base) < keep_eff;
  assign full      = KW'(held_r) >= keep_eff;

  assign rd_addr = scan_idx_r[ADDR_W-1:0];
  assign issue   = scan_idx_r < held_r;

  // the one comparator: scan compares best against memory, replace compares x against best
  assign cmp_a  = (state_r == rks_pkg::ST_REPL) ? x_r : best_val_r;
  assign cmp_b  = (state_r == rks_pkg::ST_REPL) ? best_val_r : rd_data_r;
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rks_pkg::ST_IDLE;
      keep_r      <= rks_pkg::KEEP_RESET;
      held_r      <= '0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      scan_idx_r  <= scan_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        keep_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    best_val_r  <= best_val_nxt;
    best_idx_r  <= best_idx_nxt;
    data_idx_r  <= data_idx_nxt;
    out_value_r <= out_value_nxt;
    out_held_r  <= out_held_nxt;
    out_full_r  <= out_full_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    x_nxt         = x_r;
    best_val_nxt  = best_val_r;
    best_idx_nxt  = best_idx_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = pend_r;
    first_nxt     = first_r;
    data_idx_nxt  = data_idx_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_held_nxt  = out_held_r;
    out_full_nxt  = out_full_r;
    wr_en         = 1'b0;
    wr_addr       = held_base[ADDR_W-1:0];
    wr_data       = VALUE_BITS'(in_tdata);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      rks_pkg::ST_IDLE: begin
        if (in_xfer) begin
          x_nxt        = VALUE_BITS'(in_tdata);
          scan_idx_nxt = '0;
          pend_nxt     = 1'b0;
          first_nxt    = 1'b1;
          if (append) begin
            wr_en     = 1'b1;
            held_nxt  = held_base + CNT_W'(1);
            state_nxt = rks_pkg::ST_SCAN;
          end else begin
            held_nxt  = held_base;
            state_nxt = rks_pkg::ST_FIND;
          end
        end
      end
      rks_pkg::ST_FIND, rks_pkg::ST_SCAN: begin
        // address issued this cycle, its data compared in the next
        data_idx_nxt = scan_idx_r[ADDR_W-1:0];
        if (issue) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          pend_nxt     = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          first_nxt = 1'b0;
          // strict compare keeps the lowest index among equal maxima
          if (first_r || cmp_lt) begin
            best_val_nxt = rd_data_r;
            best_idx_nxt = data_idx_r;
          end
        end
        if (!issue && !pend_r) begin
          state_nxt = (state_r == rks_pkg::ST_FIND) ? rks_pkg::ST_REPL : rks_pkg::ST_DONE;
        end
      end
      rks_pkg::ST_REPL: begin
        if (cmp_lt) begin
          wr_en        = 1'b1;
          wr_addr      = best_idx_r;
          wr_data      = x_r;
          scan_idx_nxt = '0;
          pend_nxt     = 1'b0;
          first_nxt    = 1'b1;
          state_nxt    = rks_pkg::ST_SCAN;
        end else begin
          // nothing changed, the max found is the result
          state_nxt = rks_pkg::ST_DONE;
        end
      end
      rks_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = 32'(best_val_r);
          out_held_nxt  = rks_pkg::COUNT_BITS'(held_r);
          out_full_nxt  = full;
          state_nxt     = rks_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rks_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/rks_checker.sv */
// rks_checker: port-level assertions for running_kth_smallest, bound into that module
// depends on rks_pkg for port widths
module rks_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rks_pkg::OUT_BITS-1:0]    out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every result follows at least one stored value
  a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[36:32] != 5'd0)
    else $error("result with empty store");

  // an input transfer starts a scan, so ready drops after it
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after an input transfer");

  // nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind running_kth_smallest rks_checker u_rks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/tb_top.sv */
// tb_top: self-checking bench for running_kth_smallest
// drives sample and keep-count transfers, predicts every result in-line; needs rks_pkg
module tb_top;

  localparam int KEEP_SLOTS  = rks_pkg::MAX_KEEP_DEF;
  localparam int CYCLE_LIMIT = 600000;

  // same layout as out_tdata, lowest field last
  typedef struct packed {
    logic [1:0]  pad;
    logic        full;
    logic [4:0]  count;
    logic [31:0] kth;
  } kth_result_t;

  typedef struct {
    bit          set_keep;
    logic [4:0]  keep;
    logic [31:0] sample;
    logic        restart;
    bit          typed;
    kth_result_t want;
  } step_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [rks_pkg::SAMPLE_BITS-1:0] in_tdata;   // [31:0] sample_value
  logic                          in_tuser;   // [0] restart
  logic                          out_tvalid;
  logic                          out_tready;
  // [31:0] kth_smallest, [36:32] held_count, [37] store_full, [39:38] zero
  logic [rks_pkg::OUT_BITS-1:0]    out_tdata;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rks_pkg::KEEP_BITS-1:0]   cfg_data;   // [4:0] keep_count

  running_kth_smallest uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // predictor state
  logic [4:0]   keep_reg;
  logic [31:0]  held [KEEP_SLOTS];
  int unsigned  held_n;

  kth_result_t  pending_results [$];
  kth_result_t  seen_result;
  kth_result_t  oldest_expected;
  step_row_t    steps [$];
  int           mismatches;
  int           cycles = 0;
  int           tx_idle;
  int           rx_idle;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int unsigned keep_limit();
    if (keep_reg == 5'd0) return 1;
    if (keep_reg > KEEP_SLOTS) return KEEP_SLOTS;
    return 32'(keep_reg);
  endfunction

  // first slot holding the largest value
  function automatic int unsigned largest_slot();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < held_n; i++) begin
      if ($signed(held[best]) < $signed(held[i])) best = i;
    end
    return best;
  endfunction

  function automatic kth_result_t absorb_sample(input logic [31:0] v, input logic rs);
    kth_result_t r;
    int unsigned lim;
    int unsigned slot;
    lim = keep_limit();
    if (rs) held_n = 0;
    if (held_n < lim) begin
      held[held_n] = v;
      held_n++;
    end else begin
      slot = largest_slot();
      if ($signed(v) < $signed(held[slot])) held[slot] = v;
    end
    r.kth   = held[largest_slot()];
    r.count = held_n[4:0];
    r.full  = (held_n >= lim);
    r.pad   = 2'b00;
    return r;
  endfunction

  function automatic step_row_t cfg_row(input logic [4:0] k);
    step_row_t r;
    r = '{set_keep: 1'b1, keep: k, sample: '0, restart: 1'b0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic step_row_t item_row(input logic [31:0] v, input logic rs);
    step_row_t r;
    r = '{set_keep: 1'b0, keep: '0, sample: v, restart: rs, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic step_row_t checked_row(input logic [31:0] v, input logic rs,
                                            input logic [31:0] kth, input logic [4:0] cnt,
                                            input logic full);
    step_row_t r;
    r = '{set_keep: 1'b0, keep: '0, sample: v, restart: rs, typed: 1'b1,
          want: {2'b00, full, cnt, kth}};
    return r;
  endfunction

  function automatic logic [31:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return $urandom;
    // narrow band so equal values and ties show up often
    if (sel < 80) return 32'($urandom_range(40)) - 32'd20;
    if (sel < 90) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (sel < 95) return 32'h8000_0000 + 32'($urandom_range(15));
    return 32'h7fff_ffff - 32'($urandom_range(15));
  endfunction

  task automatic note_mismatch(input string what, input logic [39:0] got,
                               input logic [39:0] want);
    mismatches++;
    $display("mismatch on %s: got %0h, want %0h (cycle %0d)", what, got, want, cycles);
  endtask

  task automatic send_sample(input logic [31:0] v, input logic rs, input bit typed,
                             input kth_result_t want);
    kth_result_t guess;
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= rs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    guess = absorb_sample(v, rs);
    pending_results.push_back(typed ? want : guess);
  endtask

  // keep count only changes once every pending result is out
  task automatic write_keep(input logic [4:0] k);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    keep_reg = k;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result = out_tdata;
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending", seen_result, '0);
      end else begin
        oldest_expected = pending_results.pop_front();
        if (seen_result.kth !== oldest_expected.kth)
          note_mismatch("kth_smallest", 40'(seen_result.kth), 40'(oldest_expected.kth));
        if (seen_result.count !== oldest_expected.count)
          note_mismatch("held_count", 40'(seen_result.count), 40'(oldest_expected.count));
        if (seen_result.full !== oldest_expected.full)
          note_mismatch("store_full", 40'(seen_result.full), 40'(oldest_expected.full));
        if (seen_result.pad !== oldest_expected.pad)
          note_mismatch("pad bits", 40'(seen_result.pad), 40'(oldest_expected.pad));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [4:0] k;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    mismatches = 0;
    tx_idle    = 30;
    rx_idle    = 67;
    keep_reg   = rks_pkg::KEEP_RESET;
    held_n     = 0;

    steps = '{
      // keep count 1 straight out of reset
      checked_row(32'd5,         1'b0, 32'd5,         5'd1, 1'b1),
      checked_row(32'hffff_fffd, 1'b0, 32'hffff_fffd, 5'd1, 1'b1),
      // equal to the largest: dropped
      checked_row(32'hffff_fffd, 1'b0, 32'hffff_fffd, 5'd1, 1'b1),
      cfg_row(5'd16),
      checked_row(32'h8000_0000, 1'b1, 32'h8000_0000, 5'd1, 1'b0),
      checked_row(32'h7fff_ffff, 1'b0, 32'h7fff_ffff, 5'd2, 1'b0),
      item_row(32'h0000_0000, 1'b0),
      item_row(32'hffff_ffff, 1'b0),
      item_row(32'h0000_0001, 1'b0),
      item_row(32'h0000_0064, 1'b0),
      item_row(32'hffff_ff9c, 1'b0),
      // lowered below the held count: nothing discarded, store stays full
      cfg_row(5'd3),
      item_row(32'h0000_0002, 1'b0),
      item_row(32'h7fff_ffff, 1'b0),
      // zero acts as one
      cfg_row(5'd0),
      checked_row(32'd10, 1'b1, 32'd10, 5'd1, 1'b1),
      checked_row(32'd10, 1'b0, 32'd10, 5'd1, 1'b1),
      checked_row(32'd9,  1'b0, 32'd9,  5'd1, 1'b1),
      // above the slot count saturates
      cfg_row(5'd31),
      item_row(32'd3,         1'b1),
      item_row(32'h8000_0000, 1'b0),
      // ties among the largest held values
      cfg_row(5'd3),
      item_row(32'd7, 1'b1),
      item_row(32'd7, 1'b0),
      item_row(32'd7, 1'b0),
      item_row(32'd2, 1'b0),
      item_row(32'd7, 1'b0)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].set_keep) write_keep(steps[i].keep);
      else send_sample(steps[i].sample, steps[i].restart, steps[i].typed, steps[i].want);
    end

    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        tx_idle = 67;
        rx_idle = 30;
      end
      if (p == 8) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      case (p % 4)
        0:       k = 5'd16;
        1:       k = 5'($urandom_range(1, 16));
        2:       k = 5'($urandom_range(31));
        default: k = 5'($urandom_range(1, 6));
      endcase
      write_keep(k);
      // rare restarts so runs fill the store and then start replacing
      for (int n = 0; n < 67; n++) begin
        send_sample(pick_sample(), logic'($urandom_range(34) == 0), 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
design/rks_pkg.sv
design/running_kth_smallest.sv
design/rks_checker.sv
tb/tb_top.sv
